// ===== src/csvw_pkg.sv =====
`timescale 1ns / 1ps
// csvw_pkg: shared types, codes and sizes for the csv row width checker
// no dependencies; imported by every module of the block

package csvw_pkg;

    // counter widths
    localparam int COUNT_BITS = 16;
    localparam int ROW_BITS   = 32;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // record terminator
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // result kinds
    localparam logic KIND_BAD  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_DELIMITER = 3'd0;
    localparam logic [2:0] REG_QUOTE     = 3'd1;
    localparam logic [2:0] REG_ESCAPE    = 3'd2;
    localparam logic [2:0] REG_QUOTING   = 3'd3;
    localparam logic [2:0] REG_BACKSLASH = 3'd4;
    localparam logic [2:0] REG_MAX_BAD   = 3'd5;

    // configuration reset values
    localparam logic [7:0] RST_DELIMITER = 8'd44;
    localparam logic [7:0] RST_QUOTE     = 8'd34;
    localparam logic [7:0] RST_ESCAPE    = 8'd92;
    localparam logic       RST_QUOTING   = 1'b1;
    localparam logic       RST_BACKSLASH = 1'b0;
    localparam logic [9:0] RST_MAX_BAD   = 10'd1000;

    // input request
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic        at_eof;
        logic        seed_inside;
        logic        seed_escaped;
        logic [15:0] seed_carry_delims;
        logic [15:0] seed_expected;
        logic        seed_have_expected;
        logic [31:0] seed_first_row;
    } in_item_t;

    // result request
    typedef struct packed {
        logic        kind;
        logic [31:0] row_number;
        logic        truncated;
        logic        all_valid;
        logic        last_of_run;
    } out_item_t;

    // up to two results pushed by the front in one cycle
    typedef struct packed {
        logic [1:0] n;
        out_item_t  first;
        out_item_t  second;
    } push_t;

endpackage

// ===== src/csvw_front.sv =====
`timescale 1ns / 1ps
// csvw_front: configuration registers, parse state and byte classification
// depends on csvw_pkg; feeds the result queue

module csvw_front
    import csvw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        accept,
    input  in_item_t    item,
    output push_t       push
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ROW_BITS-1:0]   ROW_MAX   = '1;

    // configuration registers
    logic [7:0] delim_char_reg;
    logic [7:0] quote_char_reg;
    logic [7:0] escape_char_reg;
    logic       quoting_on_reg;
    logic       backslash_reg;
    logic [9:0] max_bad_reg;

    // parse state
    logic                  in_quotes_reg, in_quotes_next;
    logic                  escape_reg, escape_next;
    logic                  content_reg, content_next;
    logic [COUNT_BITS-1:0] delim_reg, delim_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic                  have_ref_reg, have_ref_next;
    logic [COUNT_BITS-1:0] ref_reg, ref_next;
    logic [9:0]            bad_reg, bad_next;
    logic                  ovf_reg, ovf_next;

    // seed saturation and reported row
    logic [63:0] seed_delims_w;
    logic [63:0] seed_ref_w;
    logic [31:0] seed_row_m1;
    logic [63:0] seed_row_w;
    logic [63:0] rep_row_w;
    logic        quoting;
    logic        bad_end;
    out_item_t   bad_item;
    out_item_t   done_item;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_char_reg  <= RST_DELIMITER;
            quote_char_reg  <= RST_QUOTE;
            escape_char_reg <= RST_ESCAPE;
            quoting_on_reg  <= RST_QUOTING;
            backslash_reg   <= RST_BACKSLASH;
            max_bad_reg     <= RST_MAX_BAD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DELIMITER: delim_char_reg  <= cfg_data[7:0];
                REG_QUOTE:     quote_char_reg  <= cfg_data[7:0];
                REG_ESCAPE:    escape_char_reg <= cfg_data[7:0];
                REG_QUOTING:   quoting_on_reg  <= cfg_data[0];
                REG_BACKSLASH: backslash_reg   <= cfg_data[0];
                REG_MAX_BAD:   max_bad_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // seed values clipped to the counter widths
    always_comb
    begin
        seed_delims_w = 64'(item.seed_carry_delims);
        seed_ref_w    = 64'(item.seed_expected);
        seed_row_m1   = (item.seed_first_row == 32'd0) ? 32'd0
                                                       : item.seed_first_row - 32'd1;
        seed_row_w    = 64'(seed_row_m1);
        rep_row_w     = 64'((row_reg == ROW_MAX) ? row_reg : row_reg + ROW_BITS'(1));
    end

    assign quoting = quoting_on_reg;
    assign bad_end = item.at_eof && !ovf_reg &&
                     (in_quotes_reg ||
                      (content_reg && have_ref_reg && (delim_reg != ref_reg)));

    // classification and state update
    always_comb
    begin
        in_quotes_next = in_quotes_reg;
        escape_next    = escape_reg;
        content_next   = content_reg;
        delim_next     = delim_reg;
        row_next       = row_reg;
        have_ref_next  = have_ref_reg;
        ref_next       = ref_reg;
        bad_next       = bad_reg;
        ovf_next       = ovf_reg;
        push           = '0;

        bad_item.kind        = KIND_BAD;
        bad_item.row_number  = rep_row_w[31:0];
        bad_item.truncated   = 1'b0;
        bad_item.all_valid   = 1'b0;
        bad_item.last_of_run = 1'b1;
        done_item            = '0;

        if (accept)
        begin
            case (item.cmd)
                CMD_START:
                begin
                    in_quotes_next = item.seed_inside;
                    escape_next    = item.seed_escaped;
                    content_next   = 1'b0;
                    delim_next     = (seed_delims_w > 64'(COUNT_MAX)) ? COUNT_MAX
                                     : seed_delims_w[COUNT_BITS-1:0];
                    ref_next       = (seed_ref_w > 64'(COUNT_MAX)) ? COUNT_MAX
                                     : seed_ref_w[COUNT_BITS-1:0];
                    have_ref_next  = item.seed_have_expected;
                    row_next       = (seed_row_w > 64'(ROW_MAX)) ? ROW_MAX
                                     : seed_row_w[ROW_BITS-1:0];
                    bad_next       = 10'd0;
                    ovf_next       = 1'b0;
                end
                CMD_DATA:
                begin
                    if (escape_reg)
                    begin
                        escape_next  = 1'b0;
                        content_next = 1'b1;
                    end
                    else if (quoting && backslash_reg &&
                             item.data_byte == escape_char_reg)
                    begin
                        escape_next  = 1'b1;
                        content_next = 1'b1;
                    end
                    else if (quoting && item.data_byte == quote_char_reg)
                    begin
                        in_quotes_next = !in_quotes_reg;
                        content_next   = 1'b1;
                    end
                    else if (!in_quotes_reg && item.data_byte == delim_char_reg)
                    begin
                        if (delim_reg != COUNT_MAX)
                            delim_next = delim_reg + COUNT_BITS'(1);
                        content_next = 1'b1;
                    end
                    else if (!in_quotes_reg && item.data_byte == NEWLINE_BYTE)
                    begin
                        // record complete: set reference or judge it
                        if (!have_ref_reg)
                        begin
                            have_ref_next = 1'b1;
                            ref_next      = delim_reg;
                        end
                        else if (delim_reg != ref_reg && !ovf_reg)
                        begin
                            if (bad_reg == max_bad_reg)
                                ovf_next = 1'b1;
                            else
                            begin
                                bad_next   = bad_reg + 10'd1;
                                push.n     = 2'd1;
                                push.first = bad_item;
                            end
                        end
                        if (row_reg != ROW_MAX)
                            row_next = row_reg + ROW_BITS'(1);
                        delim_next   = '0;
                        content_next = 1'b0;
                    end
                    else
                        content_next = 1'b1;
                end
                CMD_END:
                begin
                    // open quote or ragged final record at end of file
                    if (bad_end)
                    begin
                        if (bad_reg == max_bad_reg)
                            ovf_next = 1'b1;
                        else
                            bad_next = bad_reg + 10'd1;
                    end
                    done_item.kind        = KIND_DONE;
                    done_item.row_number  = 32'd0;
                    done_item.truncated   = ovf_next;
                    done_item.all_valid   = (bad_next == 10'd0) && !ovf_next;
                    done_item.last_of_run = 1'b1;
                    if (bad_end && bad_reg != max_bad_reg)
                    begin
                        push.n                  = 2'd2;
                        push.first              = bad_item;
                        push.first.last_of_run  = 1'b0;
                        push.second             = done_item;
                    end
                    else
                    begin
                        push.n     = 2'd1;
                        push.first = done_item;
                    end
                end
                default: ;
            endcase
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg <= 1'b0;
            escape_reg    <= 1'b0;
            content_reg   <= 1'b0;
            delim_reg     <= '0;
            row_reg       <= '0;
            have_ref_reg  <= 1'b0;
            ref_reg       <= '0;
            bad_reg       <= 10'd0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            in_quotes_reg <= in_quotes_next;
            escape_reg    <= escape_next;
            content_reg   <= content_next;
            delim_reg     <= delim_next;
            row_reg       <= row_next;
            have_ref_reg  <= have_ref_next;
            ref_reg       <= ref_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule

// ===== src/csvw_queue.sv =====
`timescale 1ns / 1ps
// csvw_queue: short result queue, two pushes and one pop per cycle
// depends on csvw_pkg; drives the output channel of the block

module csvw_queue
    import csvw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       full,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    localparam logic [QUEUE_PTR_W:0] STALL_LEVEL = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH - 2);

    out_item_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_plus1;
    logic                   pop;

    // room for two results is kept free for the front
    assign full      = count_reg > STALL_LEVEL;
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // pointer and fill level
    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + QUEUE_PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + QUEUE_PTR_W'(push.n);
        rd_ptr_next  = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next   = count_reg + (QUEUE_PTR_W + 1)'(push.n)
                       - (QUEUE_PTR_W + 1)'(pop);
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.n == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/csv_row_width_checker.sv =====
`timescale 1ns / 1ps
// csv_row_width_checker: checks that every csv record has the same delimiter count
// results: each result is pushed into the result queue as its request is accepted and is offered from the queue head
// throughput: one request per cycle; the four-entry result queue stalls the input
// only when fewer than two entries are free
// reset: asynchronous active-low; parse state cleared, registers to defaults
// depends on csvw_pkg, csvw_front, csvw_queue

module csv_row_width_checker
    import csvw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    logic  accept;
    push_t push;

    assign accept = in_valid && !in_stall;

    // front: classify bytes and produce results
    csvw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (in_item),
        .push      (push)
    );

    // back: queue results toward the output
    csvw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ===== src/csvw_checker.sv =====
`timescale 1ns / 1ps
// csvw_checker: port-level assertions for csv_row_width_checker
// depends on csvw_pkg; bound to the top level below

module csvw_checker
    import csvw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input out_item_t  out_item
);

    // stalled request stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
    else $error("stalled request withdrawn");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

    // done summary closes its run and carries no row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_DONE
        |-> out_item.last_of_run && out_item.row_number == 32'd0)
    else $error("malformed done summary");

    // bad row report has no summary flags
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_BAD
        |-> !out_item.truncated && !out_item.all_valid)
    else $error("bad row report with summary flags");

    // truncated run cannot be all valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_DONE && out_item.truncated
        |-> !out_item.all_valid)
    else $error("truncated and all valid together");

endmodule

bind csv_row_width_checker csvw_checker u_csvw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for csv_row_width_checker, directed table then random chunks
// depends on csvw_pkg and the csv_row_width_checker rtl

module testbench;
    import csvw_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN     = 2'd3;
    localparam logic [2:0] REG_SPARE       = 3'd6;
    localparam int         RANDOM_REQUESTS = 1600;
    localparam int         PHASE_REQUESTS  = 200;
    localparam int         DRAIN_CYCLES    = 4;
    localparam int         SETTLE_CYCLES   = 10;
    localparam int         CYCLE_LIMIT     = 400000;

    // one row of the directed table: a register write or a request
    typedef struct packed {
        logic       is_cfg;
        logic [2:0] reg_index;
        logic [9:0] reg_value;
        in_item_t   req;
        logic       typed;
        logic [1:0] typed_n;
        out_item_t  t0;
        out_item_t  t1;
    } plan_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    // register copies
    logic [7:0] cfg_delim   = RST_DELIMITER;
    logic [7:0] cfg_quote   = RST_QUOTE;
    logic [7:0] cfg_escape  = RST_ESCAPE;
    logic       cfg_quoting = RST_QUOTING;
    logic       cfg_bslash  = RST_BACKSLASH;
    logic [9:0] cap_rows    = RST_MAX_BAD;

    // parse state copies
    logic        in_quote    = 1'b0;
    logic        escaping    = 1'b0;
    logic        has_content = 1'b0;
    logic        have_ref    = 1'b0;
    logic        overflowed  = 1'b0;
    logic [15:0] delims      = '0;
    logic [15:0] ref_delims  = '0;
    logic [31:0] row_count   = '0;
    logic [9:0]  bad_rows    = '0;

    out_item_t awaited_results[$];
    plan_row_t plan[$];
    out_item_t want;
    int        failures = 0;
    int        requests_sent = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        quiet = 1'b0;
    int        phase;
    int        phase_end;

    csv_row_width_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic out_item_t result_of(input logic kind, input logic [31:0] row,
                                            input logic trunc, input logic valid,
                                            input logic last);
        out_item_t r;
        r.kind        = kind;
        r.row_number  = row;
        r.truncated   = trunc;
        r.all_valid   = valid;
        r.last_of_run = last;
        return r;
    endfunction

    // row number reported for the record now closing, saturating
    function automatic logic [31:0] closing_row();
        return (row_count == '1) ? row_count : row_count + 32'd1;
    endfunction

    // count a bad record against the cap; 1 if it gets reported
    function automatic logic note_bad_row();
        if (overflowed)
            return 1'b0;
        if (bad_rows == cap_rows)
        begin
            overflowed = 1'b1;
            return 1'b0;
        end
        bad_rows = bad_rows + 10'd1;
        return 1'b1;
    endfunction

    // row width judgement for one request, updates the parse state copies
    task automatic judge_request(input in_item_t req, output int n,
                                 output out_item_t r0, output out_item_t r1);
        logic [31:0] first;
        logic [7:0]  c;
        out_item_t   done;
        n  = 0;
        r0 = '0;
        r1 = '0;
        case (req.cmd)
            CMD_START:
            begin
                first       = (req.seed_first_row == '0) ? 32'd1 : req.seed_first_row;
                in_quote    = req.seed_inside;
                escaping    = req.seed_escaped;
                has_content = 1'b0;
                delims      = req.seed_carry_delims;
                ref_delims  = req.seed_expected;
                have_ref    = req.seed_have_expected;
                row_count   = first - 32'd1;
                bad_rows    = '0;
                overflowed  = 1'b0;
            end
            CMD_DATA:
            begin
                c = req.data_byte;
                if (escaping)
                begin
                    escaping    = 1'b0;
                    has_content = 1'b1;
                end
                else if (cfg_quoting && cfg_bslash && c == cfg_escape)
                begin
                    escaping    = 1'b1;
                    has_content = 1'b1;
                end
                else if (cfg_quoting && c == cfg_quote)
                begin
                    in_quote    = !in_quote;
                    has_content = 1'b1;
                end
                else if (!in_quote && c == cfg_delim)
                begin
                    if (delims != '1)
                        delims = delims + 16'd1;
                    has_content = 1'b1;
                end
                else if (!in_quote && c == NEWLINE_BYTE)
                begin
                    if (!have_ref)
                    begin
                        have_ref   = 1'b1;
                        ref_delims = delims;
                    end
                    else if (delims != ref_delims)
                    begin
                        if (note_bad_row())
                        begin
                            r0 = result_of(KIND_BAD, closing_row(), 1'b0, 1'b0, 1'b1);
                            n  = 1;
                        end
                    end
                    if (row_count != '1)
                        row_count = row_count + 32'd1;
                    delims      = '0;
                    has_content = 1'b0;
                end
                else
                    has_content = 1'b1;
            end
            CMD_END:
            begin
                // open quote or ragged last record at end of file
                if (req.at_eof && !overflowed &&
                    (in_quote || (has_content && have_ref && delims != ref_delims)))
                begin
                    if (note_bad_row())
                    begin
                        r0 = result_of(KIND_BAD, closing_row(), 1'b0, 1'b0, 1'b0);
                        n  = 1;
                    end
                end
                done = result_of(KIND_DONE, '0, overflowed,
                                 (bad_rows == '0) && !overflowed, 1'b1);
                if (n == 0)
                    r0 = done;
                else
                    r1 = done;
                n++;
            end
            default: ;
        endcase
    endtask

    // request builders, unused fields get random values
    function automatic in_item_t rand_item();
        in_item_t r;
        r.cmd                = 2'($urandom_range(0, 3));
        r.data_byte          = 8'($urandom);
        r.at_eof             = 1'($urandom);
        r.seed_inside        = 1'($urandom);
        r.seed_escaped       = 1'($urandom);
        r.seed_carry_delims  = 16'($urandom);
        r.seed_expected      = 16'($urandom);
        r.seed_have_expected = 1'($urandom);
        r.seed_first_row     = 32'($urandom);
        return r;
    endfunction

    function automatic in_item_t mk_unknown();
        in_item_t r;
        r     = rand_item();
        r.cmd = CMD_UNKNOWN;
        return r;
    endfunction

    function automatic in_item_t mk_byte(input logic [7:0] b);
        in_item_t r;
        r           = rand_item();
        r.cmd       = CMD_DATA;
        r.data_byte = b;
        return r;
    endfunction

    function automatic in_item_t mk_end(input logic eof);
        in_item_t r;
        r        = rand_item();
        r.cmd    = CMD_END;
        r.at_eof = eof;
        return r;
    endfunction

    function automatic in_item_t mk_start(input logic quoted, input logic escaped,
                                          input logic [15:0] carry,
                                          input logic [15:0] expected,
                                          input logic have, input logic [31:0] first);
        in_item_t r;
        r                    = rand_item();
        r.cmd                = CMD_START;
        r.seed_inside        = quoted;
        r.seed_escaped       = escaped;
        r.seed_carry_delims  = carry;
        r.seed_expected      = expected;
        r.seed_have_expected = have;
        r.seed_first_row     = first;
        return r;
    endfunction

    // directed table row builders
    function automatic plan_row_t row_of(input in_item_t req);
        plan_row_t p;
        p     = '0;
        p.req = req;
        return p;
    endfunction

    function automatic plan_row_t cfg_of(input logic [2:0] idx, input logic [9:0] val);
        plan_row_t p;
        p           = '0;
        p.is_cfg    = 1'b1;
        p.reg_index = idx;
        p.reg_value = val;
        return p;
    endfunction

    function automatic plan_row_t with_results(input plan_row_t p, input logic [1:0] n,
                                               input out_item_t a, input out_item_t b);
        plan_row_t q;
        q         = p;
        q.typed   = 1'b1;
        q.typed_n = n;
        q.t0      = a;
        q.t1      = b;
        return q;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input plan_row_t p);
        plan = {plan, p};
    endfunction

    // send one request with a random gap, then record what it should produce
    task automatic send_request(input in_item_t req, input logic typed = 1'b0,
                                input logic [1:0] typed_n = '0,
                                input out_item_t t0 = '0, input out_item_t t1 = '0);
        int        gap;
        int        n;
        out_item_t p0;
        out_item_t p1;
        gap = quiet ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        judge_request(req, n, p0, p1);
        if (typed)
        begin
            n  = int'(typed_n);
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            awaited_results = {awaited_results, p0};
        if (n > 1)
            awaited_results = {awaited_results, p1};
        if (req.cmd != CMD_UNKNOWN)
            requests_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(mk_byte(b));
    endtask

    // wait for all results, then let the front settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_DELIMITER: cfg_delim   = val[7:0];
            REG_QUOTE:     cfg_quote   = val[7:0];
            REG_ESCAPE:    cfg_escape  = val[7:0];
            REG_QUOTING:   cfg_quoting = val[0];
            REG_BACKSLASH: cfg_bslash  = val[0];
            REG_MAX_BAD:   cap_rows    = val;
            default: ;
        endcase
    endtask

    // register settings per phase, first two are the extremes
    task automatic configure_phase(input int p);
        logic [7:0] d;
        logic [7:0] q;
        logic [7:0] e;
        logic       quo;
        logic       bs;
        logic [9:0] cap;
        logic [9:0] junk;
        junk = 10'($urandom);
        case (p)
            0:
            begin
                d = 8'h00; q = 8'hFF; e = 8'h80; quo = 1'b1; bs = 1'b1; cap = 10'd0;
            end
            1:
            begin
                d = 8'hFF; q = 8'h00; e = 8'hFF; quo = 1'b1; bs = 1'b1; cap = 10'd1023;
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: d = 8'h3B;
                    1: d = 8'h09;
                    2: d = 8'h7C;
                    3: d = 8'($urandom);
                    default: d = RST_DELIMITER;
                endcase
                q   = $urandom_range(0, 1) ? RST_QUOTE : 8'h27;
                e   = $urandom_range(0, 1) ? RST_ESCAPE : 8'h5E;
                quo = $urandom_range(0, 3) != 0;
                bs  = 1'($urandom);
                case ($urandom_range(0, 9))
                    0: cap = 10'd1023;
                    1, 2: cap = 10'($urandom_range(5, 1023));
                    default: cap = 10'($urandom_range(0, 4));
                endcase
            end
        endcase
        write_reg(REG_DELIMITER, {junk[9:8], d});
        write_reg(REG_QUOTE, {junk[7:6], q});
        write_reg(REG_ESCAPE, {junk[5:4], e});
        write_reg(REG_QUOTING, {junk[9:1], quo});
        write_reg(REG_BACKSLASH, {junk[8:0], bs});
        write_reg(REG_MAX_BAD, cap);
        // spare indexes must leave every register alone
        if (p % 3 == 2)
            write_reg(REG_SPARE + 3'($urandom_range(0, 1)), 10'($urandom));
    endtask

    // one field: plain, quoted, escaped or raw bytes
    task automatic send_field();
        int len;
        len = $urandom_range(0, 3);
        case ($urandom_range(0, 5))
            3:
            begin
                send_byte(cfg_quote);
                repeat (len)
                begin
                    case ($urandom_range(0, 3))
                        0: send_byte(cfg_delim);
                        1: send_byte(NEWLINE_BYTE);
                        2: send_byte(cfg_escape);
                        default: send_byte(8'(8'h61 + $urandom_range(0, 25)));
                    endcase
                end
                send_byte(cfg_quote);
            end
            4:
            begin
                send_byte(cfg_escape);
                send_byte(8'($urandom));
            end
            5: repeat (len + 1) send_byte(8'($urandom));
            default: repeat (len) send_byte(8'(8'h61 + $urandom_range(0, 25)));
        endcase
    endtask

    task automatic send_record(input int fields, input bit terminate);
        for (int f = 0; f < fields; f++)
        begin
            if (f > 0)
                send_byte(cfg_delim);
            send_field();
        end
        if (terminate)
            send_byte(NEWLINE_BYTE);
    endtask

    // a seeded chunk of mostly rectangular records
    task automatic send_chunk();
        int          fields;
        int          width;
        logic [31:0] first;
        logic [15:0] carry;
        logic [15:0] expected;
        logic        have;
        fields = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
            0: first = '0;
            1: first = $urandom;
            2: first = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: first = $urandom_range(1, 50);
        endcase
        carry = '0;
        if ($urandom_range(0, 4) == 0)
            carry = 16'($urandom);
        have     = 1'($urandom);
        expected = 16'($urandom);
        if (have && $urandom_range(0, 3) != 0)
            expected = 16'(fields - 1);
        send_request(mk_start($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                              carry, expected, have, first));
        repeat ($urandom_range(1, 6))
        begin
            width = fields;
            if ($urandom_range(0, 4) == 0)
                width = $urandom_range(1, 5);
            send_record(width, 1'b1);
        end
        // ragged tail or open quote before the end request
        case ($urandom_range(0, 3))
            0: send_record($urandom_range(1, 5), 1'b0);
            1: send_byte(cfg_quote);
            default: ;
        endcase
        send_request(mk_end(1'($urandom)));
    endtask

    // result side stall, drawn after each accepted result
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
            out_stall = 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left = quiet ? 0 : $urandom_range(0, 3);
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: kind %0d row_number %0h",
                       out_item.kind, out_item.row_number);
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_item.kind != want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, out_item.kind);
                    failures++;
                end
                if (out_item.row_number != want.row_number)
                begin
                    $error("row_number: expected %0h, actual %0h",
                           want.row_number, out_item.row_number);
                    failures++;
                end
                if (out_item.truncated != want.truncated)
                begin
                    $error("truncated: expected %0d, actual %0d",
                           want.truncated, out_item.truncated);
                    failures++;
                end
                if (out_item.all_valid != want.all_valid)
                begin
                    $error("all_valid: expected %0d, actual %0d",
                           want.all_valid, out_item.all_valid);
                    failures++;
                end
                if (out_item.last_of_run != want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, out_item.last_of_run);
                    failures++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        // end before any start: clean done from reset state
        add_row(with_results(row_of(mk_end(1'b0)), 2'd1,
                result_of(KIND_DONE, '0, 1'b0, 1'b1, 1'b1), '0));
        // bytes before any start set the reference
        add_row(row_of(mk_byte(8'h61)));
        add_row(row_of(mk_byte(RST_DELIMITER)));
        add_row(row_of(mk_byte(NEWLINE_BYTE)));
        // unknown command is dropped
        add_row(with_results(row_of(mk_unknown()), 2'd0, '0, '0));
        // seed row zero counts as row one
        add_row(with_results(row_of(mk_start(1'b0, 1'b0, 16'd0, 16'd1, 1'b1,
                32'd0)), 2'd0, '0, '0));
        add_row(row_of(mk_byte(8'h78)));
        add_row(with_results(row_of(mk_byte(NEWLINE_BYTE)), 2'd1,
                result_of(KIND_BAD, 32'd1, 1'b0, 1'b0, 1'b1), '0));
        // delimiter inside quotes is not counted
        add_row(row_of(mk_byte(RST_QUOTE)));
        add_row(row_of(mk_byte(RST_DELIMITER)));
        add_row(row_of(mk_byte(RST_QUOTE)));
        add_row(row_of(mk_byte(RST_DELIMITER)));
        add_row(row_of(mk_byte(NEWLINE_BYTE)));
        // open quote at end of file
        add_row(row_of(mk_byte(RST_QUOTE)));
        add_row(with_results(row_of(mk_end(1'b1)), 2'd2,
                result_of(KIND_BAD, 32'd3, 1'b0, 1'b0, 1'b0),
                result_of(KIND_DONE, '0, 1'b0, 1'b0, 1'b1)));
        // counters at their maximum saturate
        add_row(with_results(row_of(mk_start(1'b0, 1'b0, 16'hFFFF, 16'd0, 1'b1,
                32'hFFFF_FFFF)), 2'd0, '0, '0));
        add_row(row_of(mk_byte(RST_DELIMITER)));
        add_row(with_results(row_of(mk_byte(NEWLINE_BYTE)), 2'd1,
                result_of(KIND_BAD, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1), '0));
        add_row(row_of(mk_byte(RST_DELIMITER)));
        add_row(with_results(row_of(mk_byte(NEWLINE_BYTE)), 2'd1,
                result_of(KIND_BAD, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1), '0));
        // cap zero, quoting off, seeded escape still eats one byte
        add_row(cfg_of(REG_MAX_BAD, 10'd0));
        add_row(cfg_of(REG_QUOTING, 10'd0));
        add_row(with_results(row_of(mk_start(1'b0, 1'b1, 16'd0, 16'd0, 1'b1,
                32'd1)), 2'd0, '0, '0));
        add_row(row_of(mk_byte(RST_DELIMITER)));
        add_row(row_of(mk_byte(RST_QUOTE)));
        add_row(row_of(mk_byte(RST_DELIMITER)));
        add_row(with_results(row_of(mk_byte(NEWLINE_BYTE)), 2'd0, '0, '0));
        add_row(with_results(row_of(mk_end(1'b1)), 2'd1,
                result_of(KIND_DONE, '0, 1'b1, 1'b0, 1'b1), '0));

        // reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else
                send_request(plan[i].req, plan[i].typed, plan[i].typed_n,
                             plan[i].t0, plan[i].t1);
        end

        // random phases, each with its own register settings
        requests_sent = 0;
        phase = 0;
        while (requests_sent < RANDOM_REQUESTS)
        begin
            wait_idle();
            configure_phase(phase);
            quiet     = $urandom_range(0, 3) == 0;
            phase_end = requests_sent + PHASE_REQUESTS;
            while (requests_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4)) send_request(rand_item());
                else
                    send_chunk();
            end
            phase++;
        end

        // drain
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
src/csvw_pkg.sv
src/csvw_front.sv
src/csvw_queue.sv
src/csv_row_width_checker.sv
src/csvw_checker.sv
tb/testbench.sv
